FILE: src/jss_pkg.sv
// Shared constants and controller/datapath interface types for the Jaccard block.
package jss_pkg;

  // Default sizing
  localparam int MaxFeaturesDef = 1024;
  localparam int IdBitsDef      = 32;

  // Fixed field widths
  localparam int FeatW  = 32;
  localparam int InterW = 11;
  localparam int UnionW = 12;
  localparam int SimW   = 17;
  localparam int FracW  = 16;

  // Set selector codes
  localparam logic SetLeft  = 1'b0;
  localparam logic SetRight = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load_we;    // store the accepted transaction
    logic clr;        // empty both stores and clear result state
    logic phase;      // 0 left set pass, 1 right set pass
    logic rd_right;   // compare against right store read data
    logic addr_j;     // read address from inner index
    logic key_ld;     // capture key from read data
    logic i_clr;
    logic i_inc;
    logic j_clr;
    logic j_inc;
    logic cnt_l_inc;
    logic cnt_r_inc;
    logic inter_inc;
    logic div_start;
  } jss_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic i_eq_fill;
    logic j_eq_i;
    logic j_eq_rfill;
    logic match;
    logic div_done;
  } jss_sts_t;

endpackage

FILE: src/jaccard_set_similarity.sv
// Loading takes one transaction per cycle; after the last one the block scans the
// stored identifiers through the single read port of each store, then divides and
// hands off the result.
// Throughput: one frame at a time; input is held off from the last transaction until
// the result transaction is accepted. Reset: asynchronous active low; clears fill
// counts, drop flag and the sequencer; store contents are left as they are.
module jaccard_set_similarity import jss_pkg::*; #(
  parameter int MAX_FEATURES = MaxFeaturesDef,
  parameter int ID_BITS      = IdBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] feature_value
  input  logic [1:0]  s_axis_tuser_i,   // [0] set_select, [1] has_feature
  input  logic        s_axis_tlast_i,   // last_item
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [10:0] intersection_count,
                                        // [22:11] union count, [39:23] similarity
  output logic [0:0]  m_axis_tuser_o    // [0] overflow_flag
);

  jss_cmd_t          cmd;
  jss_sts_t          sts;
  logic [InterW-1:0] inter;
  logic [UnionW-1:0] uni;
  logic [SimW-1:0]   sim;
  logic              ovf;

  jss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  jss_datapath #(
    .MaxFeatures(MAX_FEATURES),
    .IdBits     (ID_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .set_sel_i (s_axis_tuser_i[0]),
    .has_feat_i(s_axis_tuser_i[1]),
    .feat_i    (s_axis_tdata_i),
    .inter_o   (inter),
    .union_o   (uni),
    .sim_o     (sim),
    .ovf_o     (ovf)
  );

  // Pack the result transaction
  assign m_axis_tdata_o = {sim, uni, inter};
  assign m_axis_tuser_o = ovf;

endmodule

FILE: src/jss_div.sv
// Restoring divider producing the Q1.16 ratio, one quotient bit per cycle.
module jss_div import jss_pkg::*; #(
  parameter int DivW = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [SimW-1:0] quot_o
);

  localparam int CntW = $clog2(SimW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW:0]   rem_q, rem_d;
  logic [DivW-1:0] dsr_q, dsr_d;
  logic [SimW-1:0] quot_q, quot_d;
  logic            ge;
  logic [DivW:0]   rem_sub;

  // One trial subtraction per step
  always_comb begin
    ge      = rem_q >= {1'b0, dsr_q};
    rem_sub = ge ? (rem_q - {1'b0, dsr_q}) : rem_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    quot_d  = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = {1'b0, dividend_i};
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = {rem_sub[DivW-1:0], 1'b0};
      quot_d = {quot_q[SimW-2:0], ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(SimW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: src/jss_datapath.sv
// Set stores, scan indexes, distinct and shared counters, and the ratio divider.
module jss_datapath import jss_pkg::*; #(
  parameter int MaxFeatures = MaxFeaturesDef,
  parameter int IdBits      = IdBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jss_cmd_t          cmd_i,
  output jss_sts_t          sts_o,
  input  logic              set_sel_i,
  input  logic              has_feat_i,
  input  logic [FeatW-1:0]  feat_i,
  output logic [InterW-1:0] inter_o,
  output logic [UnionW-1:0] union_o,
  output logic [SimW-1:0]   sim_o,
  output logic              ovf_o
);

  localparam int AW = $clog2(MaxFeatures);
  localparam int CW = $clog2(MaxFeatures + 1);
  localparam int UW = CW + 1;

  logic [IdBits-1:0] mem_l [MaxFeatures];
  logic [IdBits-1:0] mem_r [MaxFeatures];
  logic [IdBits-1:0] rd_l_q, rd_r_q, key_q, cmp_data, id;
  logic [CW-1:0]     fill_l_q, fill_r_q, i_q, j_q, cnt_l_q, cnt_r_q, inter_q;
  logic              drop_q;
  logic [AW-1:0]     rd_addr;
  logic              we_l, we_r, full_l, full_r;
  logic [UW-1:0]     uni;
  logic              div_done;
  logic [SimW-1:0]   quot;

  assign id      = IdBits'(feat_i);
  assign full_l  = fill_l_q == CW'(MaxFeatures);
  assign full_r  = fill_r_q == CW'(MaxFeatures);
  assign we_l    = cmd_i.load_we && has_feat_i && set_sel_i == SetLeft && !full_l;
  assign we_r    = cmd_i.load_we && has_feat_i && set_sel_i == SetRight && !full_r;
  assign rd_addr = cmd_i.addr_j ? j_q[AW-1:0] : i_q[AW-1:0];

  // Stores: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_l) mem_l[fill_l_q[AW-1:0]] <= id;
    if (we_r) mem_r[fill_r_q[AW-1:0]] <= id;
    rd_l_q <= mem_l[rd_addr];
    rd_r_q <= mem_r[rd_addr];
  end

  assign cmp_data = cmd_i.rd_right ? rd_r_q : rd_l_q;

  // Hold the outer element under test
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_ld) key_q <= cmp_data;
  end

  // Fill counts, drop flag, indexes and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_l_q <= '0;
      fill_r_q <= '0;
      drop_q   <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      cnt_l_q  <= '0;
      cnt_r_q  <= '0;
      inter_q  <= '0;
    end else if (cmd_i.clr) begin
      fill_l_q <= '0;
      fill_r_q <= '0;
      drop_q   <= 1'b0;
      cnt_l_q  <= '0;
      cnt_r_q  <= '0;
      inter_q  <= '0;
    end else begin
      if (we_l) fill_l_q <= fill_l_q + 1'b1;
      if (we_r) fill_r_q <= fill_r_q + 1'b1;
      if (cmd_i.load_we && has_feat_i &&
          ((set_sel_i == SetLeft && full_l) || (set_sel_i == SetRight && full_r)))
        drop_q <= 1'b1;
      if (cmd_i.i_clr)      i_q <= '0;
      else if (cmd_i.i_inc) i_q <= i_q + 1'b1;
      if (cmd_i.j_clr)      j_q <= '0;
      else if (cmd_i.j_inc) j_q <= j_q + 1'b1;
      if (cmd_i.cnt_l_inc) cnt_l_q <= cnt_l_q + 1'b1;
      if (cmd_i.cnt_r_inc) cnt_r_q <= cnt_r_q + 1'b1;
      if (cmd_i.inter_inc) inter_q <= inter_q + 1'b1;
    end
  end

  assign sts_o.i_eq_fill  = i_q == (cmd_i.phase ? fill_r_q : fill_l_q);
  assign sts_o.j_eq_i     = j_q == i_q;
  assign sts_o.j_eq_rfill = j_q == fill_r_q;
  assign sts_o.match      = cmp_data == key_q;
  assign sts_o.div_done   = div_done;

  assign uni = UW'(cnt_l_q) + UW'(cnt_r_q) - UW'(inter_q);

  jss_div #(
    .DivW(UW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(UW'(inter_q)),
    .divisor_i (uni),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign inter_o = InterW'(inter_q);
  assign union_o = UnionW'(uni);
  assign sim_o   = (uni == '0) ? '0 : quot;
  assign ovf_o   = drop_q;

endmodule

FILE: src/jss_ctrl.sv
// Sequencer for loading, distinct/shared scans, divide and result handoff.
module jss_ctrl import jss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  jss_sts_t sts_i,
  output jss_cmd_t cmd_o
);

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_OUT_RD   = 4'd1;
  localparam logic [3:0] S_OUT_LD   = 4'd2;
  localparam logic [3:0] S_IN_RD    = 4'd3;
  localparam logic [3:0] S_IN_CMP   = 4'd4;
  localparam logic [3:0] S_X_RD     = 4'd5;
  localparam logic [3:0] S_X_CMP    = 4'd6;
  localparam logic [3:0] S_DIV_GO   = 4'd7;
  localparam logic [3:0] S_DIV_WAIT = 4'd8;
  localparam logic [3:0] S_RESULT   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       phase_q, phase_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.phase = phase_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_we = 1'b1;
          if (in_last_i) begin
            cmd_o.i_clr = 1'b1;
            phase_d     = 1'b0;
            state_d     = S_OUT_RD;
          end
        end
      end
      S_OUT_RD: begin
        if (sts_i.i_eq_fill) begin
          if (!phase_q) begin
            phase_d     = 1'b1;
            cmd_o.i_clr = 1'b1;
          end else begin
            state_d = S_DIV_GO;
          end
        end else begin
          state_d = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        cmd_o.rd_right = phase_q;
        cmd_o.key_ld   = 1'b1;
        cmd_o.j_clr    = 1'b1;
        state_d        = S_IN_RD;
      end
      S_IN_RD: begin
        cmd_o.addr_j = 1'b1;
        if (sts_i.j_eq_i) begin
          // No earlier copy: a distinct member
          if (!phase_q) begin
            cmd_o.cnt_l_inc = 1'b1;
            cmd_o.j_clr     = 1'b1;
            state_d         = S_X_RD;
          end else begin
            cmd_o.cnt_r_inc = 1'b1;
            cmd_o.i_inc     = 1'b1;
            state_d         = S_OUT_RD;
          end
        end else begin
          state_d = S_IN_CMP;
        end
      end
      S_IN_CMP: begin
        cmd_o.rd_right = phase_q;
        if (sts_i.match) begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_OUT_RD;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d     = S_IN_RD;
        end
      end
      S_X_RD: begin
        cmd_o.addr_j = 1'b1;
        if (sts_i.j_eq_rfill) begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_OUT_RD;
        end else begin
          state_d = S_X_CMP;
        end
      end
      S_X_CMP: begin
        cmd_o.rd_right = 1'b1;
        if (sts_i.match) begin
          cmd_o.inter_inc = 1'b1;
          cmd_o.i_inc     = 1'b1;
          state_d         = S_OUT_RD;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d     = S_X_RD;
        end
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) state_d = S_RESULT;
      end
      S_RESULT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.clr = 1'b1;
          phase_d   = 1'b0;
          state_d   = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

FILE: bench/tb_jaccard_set_similarity.sv
// Self-checking testbench for the Jaccard set similarity block.
module tb_jaccard_set_similarity;
  import jss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxFeat = MaxFeaturesDef;
  localparam int IdleLimit = 5_000_000;

  typedef struct packed {
    logic [InterW-1:0] inter;
    logic [UnionW-1:0] uni;
    logic [SimW-1:0]   sim;
    logic              ovf;
  } jac_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;

  jaccard_set_similarity u_dut (.*);

  always #10 clk_i = ~clk_i;

  // Shadow of the block's frame state
  logic [31:0] shadow_left[$];
  logic [31:0] shadow_right[$];
  bit          drop_seen;
  jac_res_t    pending_scores[$];
  int          errors;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_off;
  longint      quiet_cycles;

  // Count distinct members of a, of b and of the shared set, then form the score
  function automatic jac_res_t score_sets(logic [31:0] a[$], logic [31:0] b[$], bit ovf);
    logic [31:0] ua[$];
    logic [31:0] ub[$];
    int          inter;
    int          uni;
    jac_res_t    r;
    ua = a.unique();
    ub = b.unique();
    inter = 0;
    foreach (ua[i]) begin
      foreach (ub[j]) begin
        if (ua[i] == ub[j]) inter++;
      end
    end
    uni = ua.size() + ub.size() - inter;
    r.inter = inter[InterW-1:0];
    r.uni = uni[UnionW-1:0];
    r.sim = (uni == 0) ? '0 : SimW'((longint'(inter) << FracW) / uni);
    r.ovf = ovf;
    return r;
  endfunction

  // Update the shadow state with one accepted transaction
  function automatic void model_item(bit sel, bit has, logic [31:0] id, bit last);
    if (has) begin
      if (sel == SetLeft) begin
        if (shadow_left.size() < MaxFeat) shadow_left = {shadow_left, id};
        else drop_seen = 1'b1;
      end else begin
        if (shadow_right.size() < MaxFeat) shadow_right = {shadow_right, id};
        else drop_seen = 1'b1;
      end
    end
    if (last) begin
      pending_scores = {pending_scores, score_sets(shadow_left, shadow_right, drop_seen)};
      shadow_left.delete();
      shadow_right.delete();
      drop_seen = 1'b0;
    end
  endfunction

  // Offer one transaction, honoring the sender idle rate; valid stays up
  // between back-to-back transactions and wait_drained drops it
  task automatic send_item(bit sel, bit has, logic [31:0] id, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= {has, sel};
    s_axis_tdata_i <= id;
    s_axis_tlast_i <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    model_item(sel, has, id, last);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (pending_scores.size() != 0);
  endtask

  // Receiver ready: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    m_axis_tready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    jac_res_t got;
    jac_res_t exp_r;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[10:0], m_axis_tdata_o[22:11], m_axis_tdata_o[39:23],
             m_axis_tuser_o[0]};
      if (pending_scores.size() == 0) begin
        $display("%0t: unexpected result expected none actual=%h", $realtime, got);
        errors++;
      end else begin
        exp_r = pending_scores.pop_front();
        if (got.inter !== exp_r.inter) begin
          $display("%0t: intersection expected %0d actual %0d", $realtime, exp_r.inter,
                   got.inter);
          errors++;
        end
        if (got.uni !== exp_r.uni) begin
          $display("%0t: union expected %0d actual %0d", $realtime, exp_r.uni, got.uni);
          errors++;
        end
        if (got.sim !== exp_r.sim) begin
          $display("%0t: similarity expected %0d actual %0d", $realtime, exp_r.sim,
                   got.sim);
          errors++;
        end
        if (got.ovf !== exp_r.ovf) begin
          $display("%0t: overflow expected %0d actual %0d", $realtime, exp_r.ovf, got.ovf);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [31:0] rand_id(int pool);
    return (pool == 0) ? $urandom() : 32'($urandom_range(pool));
  endfunction

  // Corner frames: empty, markers, extremes, identical, disjoint, duplicates
  task automatic test_directed();
    send_item(SetLeft, 1'b0, 32'h0, 1'b1);
    send_item(SetRight, 1'b0, 32'hFFFF_FFFF, 1'b0);
    send_item(SetLeft, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_item(SetLeft, 1'b1, 32'h0, 1'b0);
    send_item(SetRight, 1'b1, 32'h0, 1'b1);
    send_item(SetLeft, 1'b1, 32'h5, 1'b0);
    send_item(SetLeft, 1'b1, 32'h5, 1'b0);
    send_item(SetLeft, 1'b1, 32'hAAAA_5555, 1'b0);
    send_item(SetRight, 1'b1, 32'h5555_AAAA, 1'b0);
    send_item(SetRight, 1'b1, 32'h5, 1'b0);
    send_item(SetRight, 1'b0, 32'h0, 1'b1);
    send_item(SetLeft, 1'b1, 32'h1, 1'b0);
    send_item(SetLeft, 1'b1, 32'h2, 1'b0);
    send_item(SetRight, 1'b1, 32'h3, 1'b1);
    send_item(SetRight, 1'b1, 32'h7, 1'b1);
    wait_drained();
  endtask

  // Fill one store past capacity so items get dropped and flagged
  task automatic test_overflow(bit sel);
    for (int i = 0; i < MaxFeat + 3; i++) send_item(sel, 1'b1, 32'(i), 1'b0);
    send_item(!sel, 1'b1, 32'h3, 1'b0);
    send_item(!sel, 1'b1, 32'h1_0000, 1'b1);
    wait_drained();
  endtask

  // Random frames of small sets, ids from small pools to force overlap
  task automatic test_random(int frames);
    int len;
    int pool;
    for (int f = 0; f < frames; f++) begin
      len = $urandom_range(12);
      pool = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
      for (int i = 0; i < len; i++)
        send_item(1'($urandom_range(1)), $urandom_range(7) != 0, rand_id(pool), 1'b0);
      send_item(1'($urandom_range(1)), 1'($urandom_range(1)), rand_id(pool), 1'b1);
    end
    wait_drained();
  endtask

  // Hold the receiver off while frames keep arriving, so the block backs up
  task automatic test_backpressure();
    int hold;
    fork
      begin
        hold_off = 1'b1;
        hold = 0;
        while (hold < 3000) begin
          @(posedge clk_i);
          hold++;
        end
        hold_off = 1'b0;
      end
      test_random(12);
    join
  endtask

  initial begin
    errors = 0;
    quiet_cycles = 0;
    hold_off = 1'b0;
    drop_seen = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(20);
    send_idle_pct = 51;
    test_random(20);
    send_idle_pct = 0;
    recv_stall_pct = 51;
    test_random(20);
    send_idle_pct = 38;
    recv_stall_pct = 38;
    test_random(20);
    test_overflow(SetLeft);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_scores.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

FILE: jaccard_set_similarity.f
src/jss_pkg.sv
src/jss_div.sv
src/jss_datapath.sv
src/jss_ctrl.sv
src/jaccard_set_similarity.sv
bench/tb_jaccard_set_similarity.sv
